// ----- hw/rtl/spm257_pkg.sv -----
`timescale 1ns / 1ps

package spm257_pkg;

    // Field widths fixed by the item formats.
    localparam int PIXEL_W   = 8;
    localparam int THRESH_W  = 4;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 5;
    localparam int VALUE_W   = 9;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 8;
    localparam int OUT_DATA_W = 16;

    // The field modulus.
    localparam logic [VALUE_W-1:0] PRIME = 9'd257;

    // Width of acc * x + coefficient before reduction (256 * 31 + 255 fits).
    localparam int PROD_W = 15;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHARE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH,
        ST_PUSH
    } seq_state_t;

    // Reduces a value below 2^15 modulo 257, using 256 = -1 (mod 257).
    function automatic logic [VALUE_W-1:0] mod257(input logic [PROD_W-1:0] v);
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        lo = {1'b0, v[7:0]};
        hi = {2'b00, v[PROD_W-1:8]};
        if (lo >= hi) begin
            mod257 = lo - hi;
        end else begin
            mod257 = PRIME - hi + lo;
        end
    endfunction

endpackage

// ----- hw/rtl/share_polynomial_mod257_core.sv -----
`timescale 1ns / 1ps

// Share generator for polynomial secret image sharing over GF(257).
// Pixel bytes enter on the s_ channel, one item per byte, and are stored in a
// small group memory. Every threshold-th pixel closes a group: the group is
// read back as polynomial coefficients (pixel i is the coefficient of x^i)
// and the polynomial is evaluated by Horner's rule at x = 1 .. share_count.
// Each evaluation leaves on the m_ channel as one item carrying the share
// index and the 9-bit value; tlast marks the final share of the group.
// A trailing partial group is held and produces nothing.
// A pixel that does not close a group is only stored. After the closing
// pixel, each share is computed by k memory reads feeding one multiply-reduce
// unit, a step that drains it and a load of the output register. Shares are
// computed one after another, as the group memory has a single read port and
// the multiply-reduce unit is shared by all of them.
// s_tready is high whenever no group is being evaluated, also while a share
// waits in the output register. If the receiver stalls, evaluation stops at
// the output register until the share is taken. Reset (aresetn low,
// synchronous) clears the fill count, the sequencer and the output valid flag
// and restores threshold 2 and share count 4, not the group memory. The user
// must write configuration via cfg_we/cfg_index/cfg_wdata when idle; unchecked.
module share_polynomial_mod257_core #(
    parameter int MAX_K = 8,
    parameter int MAX_N = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [spm257_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spm257_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Pixel input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [spm257_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] pixel
    // Share output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [spm257_pkg::OUT_DATA_W-1:0]   m_tdata,   // [4:0] share_index,
                                                           // [13:5] share_value,
                                                           // [15:14] zero
    output logic                                m_tlast    // last_share
);
    import spm257_pkg::*;

    localparam int IDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW    = IDX_W + 1;

    // Configuration registers.
    logic [THRESH_W-1:0] threshold_reg;
    logic [COUNT_W-1:0]  share_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= THRESH_W'(2);
            share_count_reg <= COUNT_W'(4);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD:   threshold_reg   <= cfg_wdata[THRESH_W-1:0];
                REG_SHARE_COUNT: share_count_reg <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective k and n, clamped to their legal ranges.
    logic [KW-1:0]      k_eff;
    logic [COUNT_W-1:0] n_eff;

    always_comb begin
        if (threshold_reg < THRESH_W'(2)) begin
            k_eff = KW'(2);
        end else if (int'(threshold_reg) > MAX_K) begin
            k_eff = KW'(MAX_K);
        end else begin
            k_eff = KW'(threshold_reg);
        end
        if (share_count_reg < COUNT_W'(2)) begin
            n_eff = COUNT_W'(2);
        end else if (int'(share_count_reg) > MAX_N) begin
            n_eff = COUNT_W'(MAX_N);
        end else begin
            n_eff = share_count_reg;
        end
    end

    logic [IDX_W-1:0] k_top;
    assign k_top = IDX_W'(k_eff - KW'(1));

    // Sequencer and datapath registers.
    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [INDEX_W-1:0] x_reg, x_next;
    logic               mac_v_reg, mac_v_next;
    logic               mac_first_reg, mac_first_next;
    logic [VALUE_W-1:0] acc_reg;
    logic               out_v_reg, out_v_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_load;
    logic               in_accept;
    logic [KW-1:0]      fill_inc;

    // Group memory: one write port for pixels, one registered read port.
    logic [PIXEL_W-1:0] group_mem [MAX_K];
    logic [PIXEL_W-1:0] rd_data_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign fill_inc  = {1'b0, fill_reg} + KW'(1);

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            group_mem[fill_reg] <= s_tdata[PIXEL_W-1:0];
        end
        rd_data_reg <= group_mem[idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        x_next         = x_reg;
        mac_v_next     = 1'b0;
        mac_first_next = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (fill_inc >= k_eff) begin
                        fill_next  = '0;
                        x_next     = INDEX_W'(1);
                        idx_next   = k_top;
                        state_next = ST_READ;
                    end else begin
                        fill_next = fill_inc[IDX_W-1:0];
                    end
                end
            end
            ST_READ: begin
                // The read of idx_reg returns next cycle, where it is folded in.
                mac_v_next     = 1'b1;
                mac_first_next = (idx_reg == k_top);
                if (idx_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_FINISH: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (!out_v_reg || m_tready) begin
                    out_load = 1'b1;
                    if (x_reg == n_eff) begin
                        state_next = ST_IDLE;
                    end else begin
                        x_next     = x_reg + INDEX_W'(1);
                        idx_next   = k_top;
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (out_load) begin
            out_v_next = 1'b1;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end else begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            x_reg         <= INDEX_W'(1);
            mac_v_reg     <= 1'b0;
            mac_first_reg <= 1'b0;
            out_v_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            x_reg         <= x_next;
            mac_v_reg     <= mac_v_next;
            mac_first_reg <= mac_first_next;
            out_v_reg     <= out_v_next;
        end
    end

    // Horner step: acc = (acc * x + c) mod 257, starting from zero at the
    // highest coefficient.
    logic [VALUE_W-1:0] acc_in;
    logic [PROD_W-1:0]  mac_sum;

    assign acc_in  = mac_first_reg ? '0 : acc_reg;
    assign mac_sum = PROD_W'(acc_in) * PROD_W'(x_reg) + PROD_W'(rd_data_reg);

    always_ff @(posedge aclk) begin
        if (mac_v_reg) begin
            acc_reg <= mod257(mac_sum);
        end
        if (out_load) begin
            out_index_reg <= x_reg;
            out_value_reg <= acc_reg;
            out_last_reg  <= (x_reg == n_eff);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(OUT_DATA_W - INDEX_W - VALUE_W){1'b0}}, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ----- tb/share_poly_monitor.sv -----
`timescale 1ns / 1ps

module share_poly_monitor #(
    parameter int MAX_K = 8,
    parameter int MAX_N = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [spm257_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [spm257_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [spm257_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] pixel
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [spm257_pkg::OUT_DATA_W-1:0]   m_tdata,   // [4:0] share_index,
                                                           // [13:5] share_value,
                                                           // [15:14] zero
    input  logic                                m_tlast,   // last_share
    output int                                  fail_count,
    output int                                  pending
);
    import spm257_pkg::*;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        logic               last;
    } share_t;

    share_t                due_shares[$];
    logic [PIXEL_W-1:0]    coeffs[MAX_K];
    int                    threshold_reg;
    int                    count_reg;
    int                    held;
    int                    errors;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Horner evaluation of the held group, coefficient i belonging to x^i.
    function automatic logic [VALUE_W-1:0] poly_value_at(input int k, input int x);
        int acc;
        acc = 0;
        for (int i = k - 1; i >= 0; i--) begin
            acc = (acc * x + int'(coeffs[i])) % int'(PRIME);
        end
        return acc[VALUE_W-1:0];
    endfunction

    task automatic take_pixel(input logic [PIXEL_W-1:0] px);
        int     k;
        int     n;
        share_t s;
        k = clamp(threshold_reg, 2, MAX_K);
        if (held < MAX_K) begin
            coeffs[held] = px;
        end
        held++;
        if (held >= k) begin
            held = 0;
            n = clamp(count_reg, 2, MAX_N);
            for (int x = 1; x <= n; x++) begin
                s.index = x[INDEX_W-1:0];
                s.value = poly_value_at(k, x);
                s.last  = (x == n);
                due_shares.push_back(s);
            end
        end
    endtask

    task automatic check_share();
        share_t want;
        share_t got;
        got.index = m_tdata[INDEX_W-1:0];
        got.value = m_tdata[INDEX_W +: VALUE_W];
        got.last  = m_tlast;
        if (due_shares.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected share: x=%0d value=%0d last=%0b",
                         got.index, got.value, got.last);
            end
        end else begin
            want = due_shares.pop_front();
            if (got != want) begin
                errors++;
                if (errors <= 10) begin
                    $display("share mismatch: expected x=%0d value=%0d last=%0b, got x=%0d value=%0d last=%0b",
                             want.index, want.value, want.last,
                             got.index, got.value, got.last);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg = 2;
            count_reg     = 4;
            held          = 0;
            errors        = 0;
            due_shares.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_THRESHOLD) begin
                    threshold_reg = int'(cfg_wdata[THRESH_W-1:0]);
                end else if (cfg_index == REG_SHARE_COUNT) begin
                    count_reg = int'(cfg_wdata[COUNT_W-1:0]);
                end
            end
            if (m_tvalid && m_tready) begin
                check_share();
            end
            if (s_tvalid && s_tready) begin
                take_pixel(s_tdata[PIXEL_W-1:0]);
            end
        end
        fail_count <= errors;
        pending    <= due_shares.size();
    end

endmodule

// ----- tb/share_polynomial_mod257_core_tb.sv -----
`timescale 1ns / 1ps

module share_polynomial_mod257_core_tb;
    import spm257_pkg::*;

    // The run is stopped here whatever happens. The slowest correct run has
    // at most sixteen shares for every group of two or more pixels, each
    // waiting out a long receiver stall, which stays well below this figure.
    localparam int CYCLE_LIMIT = 1_000_000;
    // This covers any work still in flight once the last expected share has left.
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_PHASES = 12;
    localparam int PIXELS_PER_PHASE = 30;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;
    logic                     m_tlast;

    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;

    // Sender burst bookkeeping.
    int                       burst_left = 0;
    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int                       stall_mode = 0;
    int                       stall_left = 0;

    share_polynomial_mod257_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    share_poly_monitor i_monitor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // The receiver switches between always ready, a coin toss each cycle and
    // mostly stalled, keeping each mode for a random stretch so that stalls
    // land on every phase of a share's evaluation.
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(4, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Offers one pixel and returns at the edge where it is accepted. At the
    // start of each burst the sender may drop valid for a random gap; a burst
    // with no gap runs straight on from the previous one.
    task automatic push_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Pixels lean towards the extremes now and then; otherwise uniform.
    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Stops sending and waits until every expected share has come out, then
    // lets the block finish anything still in flight. The first edge lets the
    // monitor's count catch up with the last accepted item.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Presents one register write; the enable is left high so that a
    // following write runs on without a gap, and the caller lowers it.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic reconfigure(input int k, input int n);
        cfg_write(REG_THRESHOLD, k);
        cfg_write(REG_SHARE_COUNT, n);
        cfg_we <= 1'b0;
    endtask

    // Watchdog: a hung handshake ends the run here as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("share_polynomial_mod257_core regression: fail");
        $finish;
    end

    initial begin
        int k;
        int n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings (two pixels per group, four shares): an all-zero
        // polynomial and an all-255 one.
        push_pixel(8'h00);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'hFF);
        settle();

        // Largest group and most shares, every coefficient at its maximum,
        // so the sums wrap the modulus as often as possible.
        reconfigure(8, 16);
        repeat (8) push_pixel(8'hFF);
        settle();

        // Both registers below their range: the block must clamp to two
        // pixels per group and two shares.
        reconfigure(0, 1);
        push_pixel(8'hFF);
        push_pixel(8'h00);
        settle();

        // Threshold lowered under a partly filled group. Three pixels are
        // held at a threshold of five; the write does not clear them, and
        // the next pixel closes the group using only the first two.
        reconfigure(5, 3);
        push_pixel(8'h01);
        push_pixel(8'h80);
        push_pixel(8'h7F);
        settle();
        cfg_write(REG_THRESHOLD, 2);
        cfg_we <= 1'b0;
        push_pixel(8'hC8);
        settle();

        // Random phases. The first few pin down the corners: the heaviest
        // output load, both registers above their range, both below it, and
        // fewer shares than pixels per group. The rest mix legal settings
        // with the occasional out-of-range one. Partial groups carry over
        // from one phase to the next, so a lowered threshold often meets a
        // group that is already full enough to close on the next pixel.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin
                    k = 2;
                    n = 16;
                end
                1: begin
                    k = 15;
                    n = 31;
                end
                2: begin
                    k = 1;
                    n = 0;
                end
                3: begin
                    k = 8;
                    n = 2;
                end
                default: begin
                    k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(2, 8);
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(2, 16);
                end
            endcase
            reconfigure(k, n);
            repeat (PIXELS_PER_PHASE) push_pixel(random_pixel());
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("share_polynomial_mod257_core regression: pass");
        end else begin
            $display("share_polynomial_mod257_core regression: fail");
        end
        $finish;
    end

endmodule
